[hdl/stduck_pkg.sv]
package stduck_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CHAN_W      = 4;
	localparam int ENV_W       = 25;
	localparam int ENV_FRAC    = 23;
	localparam int THRESH_FRAC = 15;

	localparam logic [ENV_W-1:0] ENV_ONE      = ENV_W'(1) << ENV_FRAC;
	localparam logic [ENV_W-1:0] DEPTH_MARGIN = ENV_W'(41943);
	localparam logic [CFG_W-1:0] DEPTH_MAX    = CFG_W'(32768);

	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = CFG_IDX_W'(5);

	localparam logic [COEF_W-1:0] ATTACK_RESET  = COEF_W'(2949);
	localparam logic [COEF_W-1:0] RELEASE_RESET = COEF_W'(7);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_result;
		logic signed [SAMPLE_BITS-1:0] right_result;
		logic                          trigger_fired;
	} out_word_t;

endpackage

[hdl/stduck_smul.sv]
module stduck_smul #(
	parameter int A_W = 25,
	parameter int B_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic               done,
	output logic [A_W+B_W-1:0] product
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [P_W-1:0]   acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [A_W:0]     sum;

	// add the multiplicand into the top of the accumulator when the low bit is set
	assign sum = {1'b0, acc_q[P_W-1:B_W]} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[B_W-1:1]};
			b_q   <= b_q >> 1;
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

[hdl/stereo_trigger_ducker_top.sv]
// Trigger mode: the input word is registered, then the result word is loaded in the finish state.
// Ducker mode: the word passes through the prep, envelope, sample-go and scale states first.
// A new word is taken only once the engine returns to idle, so in ducker mode it waits for the
// bit-serial envelope multiply followed by the bit-serial sample multiplies.
// A finished result may wait in the output register while the next word is accepted.
// arst_n clears config to defaults, envelope to unity, ducking and all trigger flags.
module stereo_trigger_ducker_top
	import stduck_pkg::*;
#(
	parameter int CHANNEL_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int CH_N  = 1 << CHAN_W;
	localparam int EP_W  = ENV_W + COEF_W;
	localparam int SP_W  = ENV_W + SAMPLE_BITS;
	localparam int M_W   = SP_W - ENV_FRAC;
	localparam int CMP_W = SAMPLE_BITS + THRESH_FRAC;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_ENV   = 6'b000100,
		ST_SGO   = 6'b001000,
		ST_SCALE = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;

	logic              mode_q;
	logic [CHAN_W-1:0] chan_q;
	logic [CFG_W-1:0]  thresh_q;
	logic [COEF_W-1:0] attack_q;
	logic [COEF_W-1:0] release_q;
	logic [CFG_W-1:0]  depth_q;

	logic [ENV_W-1:0]         env_q;
	logic                     duck_q;
	logic [CHANNEL_COUNT-1:0] flags_q;
	logic                     up_q;

	in_word_t  in_q;
	out_word_t out_q;
	logic      out_valid_q;

	logic [CH_W-1:0]        ch_lut [CH_N];
	logic [CH_W-1:0]        ch;
	logic                   duck_eff;
	logic [CFG_W-1:0]       dep_clamp;
	logic [ENV_W-1:0]       depth_q23;
	logic [ENV_W-1:0]       target;
	logic                   up;
	logic [ENV_W-1:0]       dmag;
	logic [COEF_W-1:0]      coef;
	logic [EP_W:0]          env_rnd;
	logic [ENV_W-1:0]       step;
	logic [ENV_W-1:0]       env_new;
	logic [SAMPLE_BITS-1:0] mag_l;
	logic [SAMPLE_BITS-1:0] mag_r;
	logic                   fired;
	logic                   fin_go;
	out_word_t              out_next;

	logic                   env_busy, env_done;
	logic [EP_W-1:0]        env_prod;
	logic                   l_busy, l_done, r_busy, r_done;
	logic [SP_W-1:0]        l_prod, r_prod;

	function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
		magnitude = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
	endfunction

	// round half away from zero on the magnitude, restore the sign, saturate
	function automatic logic [SAMPLE_BITS-1:0] scale_out(input logic [SP_W-1:0] prod,
			input logic neg);
		logic [SP_W-1:0] rnd;
		logic [M_W-1:0]  m;
		logic [M_W-1:0]  lim;
		rnd = prod + (SP_W'(1) << (ENV_FRAC - 1));
		m   = rnd[SP_W-1:ENV_FRAC];
		if (neg) begin
			lim = M_W'(1) << (SAMPLE_BITS - 1);
			scale_out = (m > lim) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
				SAMPLE_BITS'(~m + M_W'(1));
		end else begin
			lim = (M_W'(1) << (SAMPLE_BITS - 1)) - M_W'(1);
			scale_out = (m > lim) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : SAMPLE_BITS'(m);
		end
	endfunction

	always_comb begin
		for (int i = 0; i < CH_N; i++) begin
			ch_lut[i] = CH_W'(i % CHANNEL_COUNT);
		end
	end

	assign ch        = ch_lut[chan_q];
	assign duck_eff  = duck_q | flags_q[ch];
	assign dep_clamp = (depth_q > DEPTH_MAX) ? DEPTH_MAX : depth_q;
	assign depth_q23 = {1'b0, dep_clamp, 8'b0};
	assign target    = duck_eff ? depth_q23 : ENV_ONE;
	assign up        = (target >= env_q);
	assign dmag      = up ? (target - env_q) : (env_q - target);
	assign coef      = up ? release_q : attack_q;

	assign env_rnd = {1'b0, env_prod} + (EP_W + 1)'(1 << (COEF_W - 1));
	assign step    = env_rnd[COEF_W +: ENV_W];
	assign env_new = up_q ? (env_q + step) : (env_q - step);

	assign mag_l = magnitude(in_q.left_sample);
	assign mag_r = magnitude(in_q.right_sample);
	assign fired = ({mag_l, {THRESH_FRAC{1'b0}}} > CMP_W'({thresh_q, {(SAMPLE_BITS-1){1'b0}}}))
		|| ({mag_r, {THRESH_FRAC{1'b0}}} > CMP_W'({thresh_q, {(SAMPLE_BITS-1){1'b0}}}));

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		if (!mode_q) begin
			out_next.left_result   = in_q.left_sample;
			out_next.right_result  = in_q.right_sample;
			out_next.trigger_fired = fired;
		end else begin
			out_next.left_result   = scale_out(l_prod, in_q.left_sample[SAMPLE_BITS-1]);
			out_next.right_result  = scale_out(r_prod, in_q.right_sample[SAMPLE_BITS-1]);
			out_next.trigger_fired = 1'b0;
		end
	end

	stduck_smul #(.A_W(ENV_W), .B_W(COEF_W)) u_env_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_PREP),
		.a       (dmag),
		.b       (coef),
		.busy    (env_busy),
		.done    (env_done),
		.product (env_prod)
	);

	stduck_smul #(.A_W(ENV_W), .B_W(SAMPLE_BITS)) u_left_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_SGO),
		.a       (env_q),
		.b       (mag_l),
		.busy    (l_busy),
		.done    (l_done),
		.product (l_prod)
	);

	stduck_smul #(.A_W(ENV_W), .B_W(SAMPLE_BITS)) u_right_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_SGO),
		.a       (env_q),
		.b       (mag_r),
		.busy    (r_busy),
		.done    (r_done),
		.product (r_prod)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			chan_q    <= '0;
			thresh_q  <= '0;
			attack_q  <= ATTACK_RESET;
			release_q <= RELEASE_RESET;
			depth_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:      mode_q    <= cfg_data[0];
				CFG_CHANNEL:   chan_q    <= cfg_data[CHAN_W-1:0];
				CFG_THRESHOLD: thresh_q  <= cfg_data;
				CFG_ATTACK:    attack_q  <= cfg_data;
				CFG_RELEASE:   release_q <= cfg_data;
				CFG_DEPTH:     depth_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			env_q       <= ENV_ONE;
			duck_q      <= 1'b0;
			flags_q     <= '0;
			up_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= mode_q ? ST_PREP : ST_FIN;
					end
				end
				ST_PREP: begin
					// consume the selected flag and fix the step direction
					duck_q      <= duck_eff;
					flags_q[ch] <= 1'b0;
					up_q        <= up;
					state_q     <= ST_ENV;
				end
				ST_ENV: begin
					if (env_done) begin
						env_q <= env_new;
						if (duck_q && (env_new <= depth_q23 + DEPTH_MARGIN)) begin
							duck_q <= 1'b0;
						end
						state_q <= ST_SGO;
					end
				end
				ST_SGO: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (l_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (fin_go) begin
						out_valid_q <= 1'b1;
						if (!mode_q && fired) begin
							flags_q[ch] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (fin_go) begin
			out_q <= out_next;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_ONE)
		else $error("envelope above unity");

	a_lanes_align: assert property (@(posedge clk) disable iff (!arst_n)
		l_done == r_done)
		else $error("left and right multipliers out of step");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result word loaded outside the finish state");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(env_busy || l_busy || r_busy))
		else $error("multiplier busy while engine idle");

endmodule

[tb/sv/tb_stereo_trigger_ducker_top.sv]
`timescale 1ns / 100ps

module tb_stereo_trigger_ducker_top;
	import stduck_pkg::*;

	localparam int CHANNEL_COUNT = 16;
	localparam int RANDOM_WORDS  = 500;
	localparam int CYCLE_LIMIT   = 600_000;
	localparam int DRAIN_CYCLES  = 40;

	localparam logic [CFG_W-1:0]     MODE_TRIGGER = CFG_W'(0);
	localparam logic [CFG_W-1:0]     MODE_DUCKER  = CFG_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B  = CFG_IDX_W'(7);

	class duck_scoreboard;
		logic                     mode;
		logic [CHAN_W-1:0]        chan;
		logic [CFG_W-1:0]         thresh;
		logic [COEF_W-1:0]        atk_coef;
		logic [COEF_W-1:0]        rel_coef;
		logic [CFG_W-1:0]         depth;
		logic [ENV_W-1:0]         env;
		logic                     ducking;
		logic [CHANNEL_COUNT-1:0] flags;
		out_word_t                expected_q[$];
		int                       errors;
		int                       checked;
		int                       fired_count;
		int                       onset_count;

		function new();
			mode        = 1'b0;
			chan        = '0;
			thresh      = '0;
			atk_coef    = ATTACK_RESET;
			rel_coef    = RELEASE_RESET;
			depth       = '0;
			env         = ENV_ONE;
			ducking     = 1'b0;
			flags       = '0;
			errors      = 0;
			checked     = 0;
			fired_count = 0;
			onset_count = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_MODE:      mode = val[0];
				CFG_CHANNEL:   chan = val[CHAN_W-1:0];
				CFG_THRESHOLD: thresh = val;
				CFG_ATTACK:    atk_coef = val;
				CFG_RELEASE:   rel_coef = val;
				CFG_DEPTH:     depth = val;
				default: ;
			endcase
		endfunction

		function logic [SAMPLE_BITS:0] magnitude(logic signed [SAMPLE_BITS-1:0] s);
			logic signed [SAMPLE_BITS:0] x;
			x = s;
			return (x < 0) ? -x : x;
		endfunction

		// round half away from zero, then clamp to the sample range
		function logic signed [SAMPLE_BITS-1:0] apply_gain(logic signed [SAMPLE_BITS-1:0] s);
			longint unsigned scaled;
			longint          r;
			longint          hi;
			hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
			scaled = magnitude(s);
			scaled = (scaled * env + (64'd1 << (ENV_FRAC - 1))) >> ENV_FRAC;
			r = (s < 0) ? -longint'(scaled) : longint'(scaled);
			if (r > hi)
				r = hi;
			if (r < -hi - 1)
				r = -hi - 1;
			return SAMPLE_BITS'(r);
		endfunction

		function void note_input(in_word_t w);
			int              idx;
			longint unsigned dep_q23;
			longint unsigned target;
			longint unsigned diff;
			longint unsigned step;
			out_word_t       e;
			idx = chan % CHANNEL_COUNT;
			e.trigger_fired = 1'b0;
			if (!mode) begin
				e.left_result  = w.left_sample;
				e.right_result = w.right_sample;
				if (magnitude(w.left_sample) > thresh || magnitude(w.right_sample) > thresh) begin
					e.trigger_fired = 1'b1;
					flags[idx] = 1'b1;
					fired_count++;
				end
			end else begin
				dep_q23 = (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
				dep_q23 = dep_q23 << (ENV_FRAC - THRESH_FRAC);
				if (flags[idx]) begin
					ducking = 1'b1;
					flags[idx] = 1'b0;
					onset_count++;
				end
				target = ducking ? dep_q23 : longint'(ENV_ONE);
				if (target >= env) begin
					diff = target - env;
					step = (diff * rel_coef + 64'd32768) >> 16;
					env  = ENV_W'(env + step);
				end else begin
					diff = env - target;
					step = (diff * atk_coef + 64'd32768) >> 16;
					env  = ENV_W'(env - step);
				end
				if (ducking && env <= dep_q23 + DEPTH_MARGIN)
					ducking = 1'b0;
				e.left_result  = apply_gain(w.left_sample);
				e.right_result = apply_gain(w.right_sample);
			end
			expected_q.push_back(e);
		endfunction

		task report(string what, int got, int want);
			$display("[%0t] result %0d %s: got %0d, expected %0d", $time, checked, what, got,
				want);
			errors++;
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			if (expected_q.size() == 0) begin
				report("word with nothing expected, left_result", got.left_result, 0);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.left_result !== want.left_result)
				report("left_result", got.left_result, want.left_result);
			if (got.right_result !== want.right_result)
				report("right_result", got.right_result, want.right_result);
			if (got.trigger_fired !== want.trigger_fired)
				report("trigger_fired", got.trigger_fired, want.trigger_fired);
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_word_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	duck_scoreboard sb;
	int send_idle  = 36;
	int recv_idle  = 55;
	int cycles     = 0;
	int words_sent = 0;
	int cfg_writes = 0;

	stereo_trigger_ducker_top #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stall the result side at random and score every word taken
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// leave cfg_valid high; the caller drops it after the last write of a group
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
		in_word_t w;
		w.left_sample  = l;
		w.right_sample = r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
		words_sent++;
	endtask

	// hold off until every word sent has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			1, 2: return SAMPLE_BITS'($urandom_range(600)) - SAMPLE_BITS'(300);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_threshold();
		case ($urandom_range(7))
			0: return '0;
			1: return DEPTH_MAX;
			2: return CFG_W'($urandom_range(65535, 32769));
			default: return CFG_W'($urandom_range(20000));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_coef(input int lo);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom_range(65535, lo));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_depth();
		case ($urandom_range(7))
			0: return '0;
			1: return DEPTH_MAX;
			2: return CFG_W'($urandom_range(65535, 32769));
			default: return CFG_W'($urandom_range(32768));
		endcase
	endfunction

	initial begin
		int ch;
		int n_trig;
		int n_duck;
		int rand_sent;
		sb = new();
		rand_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// trigger mode at reset settings: threshold zero, so any nonzero sample fires
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h0001, 16'h0000);
		send_pair(16'h0000, 16'hffff);
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		drain();
		write_reg(CFG_THRESHOLD, DEPTH_MAX);
		cfg_valid <= 1'b0;
		send_pair(16'h8000, 16'h0000);
		send_pair(16'h7fff, 16'h8001);
		drain();
		write_reg(CFG_THRESHOLD, '1);
		// spare indexes must leave every register alone
		write_reg(CFG_SPARE_A, CFG_W'($urandom));
		write_reg(CFG_SPARE_B, CFG_W'($urandom));
		cfg_valid <= 1'b0;
		send_pair(16'h8000, 16'h8000);
		drain();
		// depth above unity clamps to unity, so ducking ends at once
		write_reg(CFG_MODE, MODE_DUCKER);
		write_reg(CFG_DEPTH, '1);
		cfg_valid <= 1'b0;
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		drain();
		write_reg(CFG_MODE, MODE_TRIGGER);
		write_reg(CFG_CHANNEL, CFG_W'(CHANNEL_COUNT - 1));
		write_reg(CFG_THRESHOLD, CFG_W'(100));
		cfg_valid <= 1'b0;
		send_pair(16'h0065, 16'h0000);
		send_pair(16'h0064, 16'hff9c);
		send_pair(16'h0000, 16'hff9b);
		drain();
		write_reg(CFG_MODE, MODE_DUCKER);
		write_reg(CFG_DEPTH, '0);
		write_reg(CFG_ATTACK, '1);
		cfg_valid <= 1'b0;
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h7fff, 16'h8000);
		drain();
		write_reg(CFG_RELEASE, '1);
		cfg_valid <= 1'b0;
		send_pair(16'h7fff, 16'h8000);
		drain();
		write_reg(CFG_RELEASE, '0);
		write_reg(CFG_CHANNEL, CFG_W'(3));
		cfg_valid <= 1'b0;
		send_pair(16'h1234, 16'hedcc);
		send_pair(16'hffff, 16'h0001);
		drain();
		write_reg(CFG_MODE, MODE_TRIGGER);
		write_reg(CFG_THRESHOLD, '0);
		cfg_valid <= 1'b0;
		send_pair(16'h0005, 16'h0005);
		drain();
		// zero attack freezes the envelope while ducking
		write_reg(CFG_MODE, MODE_DUCKER);
		write_reg(CFG_ATTACK, '0);
		write_reg(CFG_RELEASE, RELEASE_RESET);
		write_reg(CFG_DEPTH, CFG_W'(16384));
		cfg_valid <= 1'b0;
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h4000, 16'hc000);
		drain();
		write_reg(CFG_ATTACK, ATTACK_RESET);
		cfg_valid <= 1'b0;
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);

		// random trigger bursts, each followed by a ducking run on the same flag mostly
		while (rand_sent < RANDOM_WORDS) begin
			if (rand_sent < RANDOM_WORDS / 3) begin
				send_idle = 36;
				recv_idle = 55;
			end else if (rand_sent < 2 * RANDOM_WORDS / 3) begin
				send_idle = 55;
				recv_idle = 36;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			ch     = $urandom_range(CHANNEL_COUNT - 1);
			n_trig = $urandom_range(12, 2);
			n_duck = $urandom_range(30, 8);
			drain();
			write_reg(CFG_MODE, MODE_TRIGGER);
			write_reg(CFG_CHANNEL, CFG_W'(ch));
			write_reg(CFG_THRESHOLD, rand_threshold());
			cfg_valid <= 1'b0;
			repeat (n_trig) send_pair(rand_sample(), rand_sample());
			drain();
			write_reg(CFG_MODE, MODE_DUCKER);
			if ($urandom_range(4) == 0)
				write_reg(CFG_CHANNEL, CFG_W'($urandom_range(CHANNEL_COUNT - 1)));
			write_reg(CFG_ATTACK, rand_coef(3000));
			write_reg(CFG_RELEASE, rand_coef(500));
			write_reg(CFG_DEPTH, rand_depth());
			cfg_valid <= 1'b0;
			repeat (n_duck) send_pair(rand_sample(), rand_sample());
			rand_sent += n_trig + n_duck;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d sample pairs through %0d register writes, both modes, all idle mixes.",
			words_sent, cfg_writes);
		$display("Checked %0d results: %0d trigger crossings, %0d ducking onsets, %0d errors.",
			sb.checked, sb.fired_count, sb.onset_count, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
hdl/stduck_pkg.sv
hdl/stduck_smul.sv
hdl/stereo_trigger_ducker_top.sv
tb/sv/tb_stereo_trigger_ducker_top.sv
